### design/sha_pkg.sv
// Package holding SHA-256 constants, shared types and round functions.
package sha_pkg;

    localparam int unsigned QDepth  = 4;
    localparam int unsigned QAw     = 2;
    localparam int unsigned Rounds  = 64;
    localparam logic [7:0]  PadByte = 8'h80;
    localparam logic [5:0]  LenPos  = 6'd56;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [31:0] word_t;

    // Command from the front part to the compression engine.
    typedef struct packed {
        logic   finish;
        word_t [15:0] block;
    } blk_cmd_t;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        unique case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t h;
        unique case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### design/sha256_stream_hash_top.sv
// Top level of the SHA-256 byte stream hasher.
//
//   Channel | Handshake          | Payload
//   input   | in_valid/in_stall  | op, data_byte
//   output  | out_valid/out_stall| digest_word, word_index, last
//
// The front part stores each absorb byte in its buffer; every 64th byte pushes a
// block into a four-entry queue. The compression engine handles a block in
// steps (load, 64 rounds at one per cycle, chaining add), so the long-run rate
// is set by the single round unit. A finish word costs a padding run in the
// front part, one or two compressions, and eight output words, one per
// unstalled cycle. Reset restores the initial hash words and empties the
// queue; the input stalls while padding runs or while the queue is full.
module sha256_stream_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);
    import sha_pkg::*;

    logic     push, q_full, pop, q_ne;
    blk_cmd_t push_cmd, q_head;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .op(op), .data_byte(data_byte), .push(push), .push_cmd(push_cmd),
        .q_full(q_full)
    );

    sha_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .full(q_full),
        .pop(pop), .not_empty(q_ne), .head(q_head)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_head(q_head), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .last(last)
    );

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full)) else $error("block queue overflow");

    // The last flag marks exactly the eighth digest word.
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (word_index == 3'd7))) else $error("last flag misplaced");

    // After the final word is taken, no further word follows at once.
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid) else $error("extra digest word");
endmodule

### design/sha_front.sv
// Front part: packs bytes into blocks, pads on finish, and pushes blocks.
module sha_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,
    output logic                stall,
    input  logic                op,
    input  logic [7:0]          data_byte,
    output logic                push,
    output sha_pkg::blk_cmd_t   push_cmd,
    input  logic                q_full
);
    import sha_pkg::*;

    localparam logic [1:0] S_BYTES = 2'd0;
    localparam logic [1:0] S_PAD   = 2'd1;
    localparam logic [1:0] S_LEN   = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [7:0]  buf_reg [64];
    logic        wr_en;
    logic [7:0]  wr_data;
    logic        take;
    word_t [15:0] blk;

    // The block is assembled from the buffer plus the byte written this cycle.
    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                blk[w][31-8*b -: 8] = (wr_en && fill_reg == 6'(4*w+b)) ?
                                      wr_data : buf_reg[4*w+b];
            end
        end
    end

    assign take  = valid && !stall;
    assign stall = (state_reg != S_BYTES) || q_full;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        wr_en      = 1'b0;
        wr_data    = data_byte;
        push       = 1'b0;
        push_cmd.finish = 1'b0;
        push_cmd.block  = blk;
        unique case (state_reg)
            S_BYTES:
            begin
                if (take && op == OP_ABSORB)
                begin
                    wr_en     = 1'b1;
                    bits_next = bits_reg + 64'd8;
                    fill_next = fill_reg + 6'd1;
                    push      = (fill_reg == 6'd63);
                end
                else if (take)
                begin
                    wr_en   = 1'b1;
                    wr_data = PadByte;
                    fill_next = fill_reg + 6'd1;
                    // A marker in the last byte closes the block at once.
                    push    = (fill_reg == 6'd63);
                    state_next = (fill_reg >= 6'd56 && fill_reg != 6'd63) ? S_PAD : S_LEN;
                end
            end
            S_PAD:
            begin
                // Zero fill one byte a cycle; the last one closes the block and waits while the queue is full.
                if (!q_full || fill_reg != 6'd63)
                begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                    fill_next = fill_reg + 6'd1;
                    push    = (fill_reg == 6'd63);
                    if (fill_reg == 6'd63)
                        state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (fill_reg < LenPos)
                begin
                    wr_en     = 1'b1;
                    wr_data   = '0;
                    fill_next = fill_reg + 6'd1;
                end
                else if (!q_full || fill_reg != 6'd63)
                begin
                    wr_en   = 1'b1;
                    wr_data = bits_reg[63 - 8*(32'(fill_reg) - 56) -: 8];
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        push            = 1'b1;
                        push_cmd.finish = 1'b1;
                        bits_next       = '0;
                        state_next      = S_BYTES;
                    end
                end
            end
            default: state_next = S_BYTES;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_reg[fill_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BYTES;
            fill_reg  <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
    end
endmodule

### design/sha_queue.sv
// Short block queue between the front part and the compression engine.
module sha_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sha_pkg::blk_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output sha_pkg::blk_cmd_t  head
);
    import sha_pkg::*;

    blk_cmd_t        mem_reg [QDepth];
    logic [QAw-1:0]  wp_reg, rp_reg;
    logic [QAw:0]    cnt_reg;

    assign full      = (cnt_reg == (QAw+1)'(QDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAw+1)'(push) - (QAw+1)'(pop);
        end
    end
endmodule

### design/sha_core.sv
// Back part: one SHA-256 round per cycle, chaining update and digest output.
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sha_pkg::blk_cmd_t  q_head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last
);
    import sha_pkg::*;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_RUN   = 2'd1;
    localparam logic [1:0] C_ADD   = 2'd2;
    localparam logic [1:0] C_EMIT  = 2'd3;

    logic [1:0]   state_reg;
    logic [5:0]   rnd_reg;
    logic         fin_reg;
    logic [2:0]   idx_reg;
    word_t [7:0]  h_reg;
    word_t [7:0]  v_reg;
    word_t [15:0] w_reg;
    word_t        wt, s0, s1, t1, t2, wnew;

    always_comb
    begin
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        wt   = w_reg[0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign pop         = (state_reg == C_IDLE) && q_valid;
    assign out_valid   = (state_reg == C_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last        = (idx_reg == 3'd7);

    // Window slot 0 always holds the word for the current round.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg <= q_head.block;
            v_reg <= h_reg;
        end
        else if (state_reg == C_RUN)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            v_reg <= {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (q_valid)
                    begin
                        fin_reg   <= q_head.finish;
                        rnd_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'(Rounds - 1))
                        state_reg <= C_ADD;
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg   <= '0;
                    state_reg <= fin_reg ? C_EMIT : C_IDLE;
                end
                C_EMIT:
                begin
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= init_hash(3'(i));
                            state_reg <= C_IDLE;
                        end
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end
endmodule

### test/tb_sha256_stream_hash_top.sv
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 100ps

module tb_sha256_stream_hash_top;
    import sha_pkg::*;

    // Digest words expected at the output, one entry per word.
    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } digest_entry_t;

    localparam int unsigned IdleLimit = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    // Predictor state: the running hash of the message being absorbed.
    logic [31:0] hash_chain [8];
    logic [7:0]  pending_block [64];
    int unsigned pending_fill;
    logic [63:0] bit_length;

    digest_entry_t expected_digests[$];
    int unsigned   error_count = 0;
    int unsigned   words_sent = 0;
    int unsigned   digests_seen = 0;
    int unsigned   blocks_absorbed = 0;
    int unsigned   idle_cycles = 0;
    bit            long_gaps = 1'b1;

    sha256_stream_hash_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .data_byte(data_byte), .out_valid(out_valid),
        .out_stall(out_stall), .digest_word(digest_word),
        .word_index(word_index), .last(last)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Returns a gap length: mostly zero or short, now and then long.
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (!long_gaps || roll < 55)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic restart_hash();
        hash_chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        pending_fill = 0;
        bit_length = '0;
    endtask

    // Folds the 64-byte pending block into the chaining words.
    task automatic compress_pending();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, k;
        for (int i = 0; i < 16; i++)
            w[i] = {pending_block[4*i], pending_block[4*i+1],
                    pending_block[4*i+2], pending_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        {a, b, c, d, e, f, g, h} = {hash_chain[0], hash_chain[1], hash_chain[2],
                                    hash_chain[3], hash_chain[4], hash_chain[5],
                                    hash_chain[6], hash_chain[7]};
        for (int r = 0; r < 64; r++)
        begin
            k = round_k(r[5:0]);
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + k + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endtask

    // Updates the predictor with one accepted word and queues any digest.
    task automatic predict_word(input logic word_op, input logic [7:0] value);
        digest_entry_t entry;
        if (word_op == OP_ABSORB)
        begin
            pending_block[pending_fill] = value;
            pending_fill++;
            bit_length += 64'd8;
            if (pending_fill == 64)
            begin
                compress_pending();
                blocks_absorbed++;
                pending_fill = 0;
            end
            return;
        end
        // Padding: the marker byte, zeros, then the big-endian bit length.
        pending_block[pending_fill] = PadByte;
        pending_fill++;
        if (pending_fill > LenPos)
        begin
            while (pending_fill < 64)
                pending_block[pending_fill++] = 8'h00;
            compress_pending();
            pending_fill = 0;
        end
        while (pending_fill < LenPos)
            pending_block[pending_fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            pending_block[56 + i] = bit_length[63 - 8*i -: 8];
        compress_pending();
        for (int i = 0; i < 8; i++)
        begin
            entry.digest_word = hash_chain[i];
            entry.word_index = i[2:0];
            entry.last = (i == 7);
            expected_digests.push_back(entry);
        end
        restart_hash();
    endtask

    // Drives one word, holding it until the block accepts it. Valid drops
    // only for a gap, so back-to-back words keep it high.
    task automatic send_word(input logic word_op, input logic [7:0] value);
        int unsigned gap;
        gap = gap_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            op <= 1'($urandom_range(1));
            data_byte <= 8'($urandom_range(255));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= word_op;
        data_byte <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(word_op, value);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int unsigned length);
        for (int unsigned i = 0; i < length; i++)
            send_word(OP_ABSORB, 8'($urandom_range(255)));
        send_word(OP_FINISH, 8'($urandom_range(255)));
    endtask

    // Directed cases: the empty message, byte extremes, and short messages.
    task automatic test_directed();
        send_word(OP_FINISH, 8'hff);
        send_word(OP_ABSORB, 8'h00);
        send_word(OP_FINISH, 8'h00);
        send_word(OP_ABSORB, 8'hff);
        send_word(OP_ABSORB, 8'h5a);
        send_word(OP_ABSORB, 8'ha5);
        send_word(OP_FINISH, 8'h80);
        send_message(4);
        send_message(2);
    endtask

    // Messages whose length lands at 55, 56, 63 and 64 bytes, the edges of the
    // padding rules; the last one is an exact block followed by a pad block.
    task automatic test_padding_edges();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
    endtask

    // Random short messages, all finished so their digests are checked.
    task automatic test_random_messages();
        int unsigned budget;
        budget = words_sent + 30;
        while (words_sent < budget)
            send_message($urandom_range(20));
    endtask

    // Back-to-back traffic with no gaps on either side.
    task automatic test_full_rate();
        long_gaps = 1'b0;
        send_message(12);
        send_message(0);
        send_message(9);
        long_gaps = 1'b1;
    endtask

    // The receiver stalls at random, cycle by cycle; it never stalls while gaps are off.
    always @(negedge clk)
    begin
        if (long_gaps && $urandom_range(3) == 0)
            out_stall <= ($urandom_range(9) != 0);
        else if (!long_gaps)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(4) == 0);
    end

    // Compares every accepted digest word against the oldest prediction.
    always @(posedge clk)
    begin
        digest_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digests.size() == 0)
            begin
                $error("digest word %h with no word expected", digest_word);
                error_count++;
            end
            else
            begin
                want = expected_digests.pop_front();
                if (digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h", want.digest_word, digest_word);
                    error_count++;
                end
                if (word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d", want.word_index, word_index);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    error_count++;
                end
                if (want.last)
                    digests_seen++;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("timeout after %0d idle cycles", IdleLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        restart_hash();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_padding_edges();
        test_full_rate();
        test_random_messages();
        in_valid <= 1'b0;
        while (expected_digests.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d words in %0d full blocks; checked %0d digests.",
                 words_sent, blocks_absorbed, digests_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
